// ===== hw/rtl/prca_pkg.sv =====
package prca_pkg;

   localparam int NUM_PAGES   = 1024;
   localparam int PAGE_BYTES  = 4096;
   localparam int REF_CEILING = 255;

   localparam int FUNC_W     = 2;
   localparam int BYTES_W    = 23;
   localparam int ADDR_W     = 22;
   localparam int COUNT_W    = 8;
   localparam int IDX_W      = $clog2(NUM_PAGES);
   localparam int RUN_W      = $clog2(NUM_PAGES + 1);
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int NEED_W     = BYTES_W + 1 - PAGE_SHIFT;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ALLOC = 2'd0,
      FUNC_INC   = 2'd1,
      FUNC_FREE  = 2'd2
   } prca_func_type;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [BYTES_W-1:0] request_bytes;
      logic [ADDR_W-1:0]  page_address;
   } prca_req_type;

   typedef struct packed {
      logic              ok;
      logic [ADDR_W-1:0] alloc_address;
   } prca_rsp_type;

endpackage

// ===== hw/rtl/prca_channels.sv =====
interface prca_req_if;
   import prca_pkg::*;
   logic         valid;
   logic         ready;
   prca_req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface prca_rsp_if;
   import prca_pkg::*;
   logic         valid;
   logic         ready;
   prca_rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/page_refcount_allocator_unit.sv =====
// Page reference-count allocator: one 8-bit count per page, kept in a simple dual-port
// synchronous RAM (one read, one write per cycle, read data registered). After
// reset the block sweeps all NUM_PAGES (1024) entries to zero and accepts no
// item until that ends. Allocate reads the page map one entry per cycle from the top
// page down until it finds a free run of the needed length, or fails at page zero;
// it then writes a count of one to each page of the run and presents the result.
// A request for zero pages or more than NUM_PAGES pages fails without a scan, as
// does an unused function code. Increment and free read, modify and write one entry.
// One item is in work at a time; a result waiting in the output register does not
// stop the next item from being accepted.
module page_refcount_allocator_unit (
   input logic          clock,
   input logic          reset,
   prca_req_if.sink     req_if,
   prca_rsp_if.source   rsp_if
);
   import prca_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FILL,
      ST_RMW,
      ST_DONE
   } state_type;

   logic [COUNT_W-1:0] mem [NUM_PAGES];

   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [COUNT_W-1:0] mem_wdata;
   logic [IDX_W-1:0]   mem_raddr;
   logic [COUNT_W-1:0] rd_data_ff;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   ptr_ff, ptr_in;
   logic [RUN_W-1:0]   left_ff, left_in;
   logic [IDX_W-1:0]   scan_addr_ff, scan_addr_in;
   logic               scan_more_ff, scan_more_in;
   logic               eval_valid_ff, eval_valid_in;
   logic [IDX_W-1:0]   eval_idx_ff, eval_idx_in;
   logic [RUN_W-1:0]   run_top_ff, run_top_in;
   logic [RUN_W-1:0]   need_ff, need_in;
   logic [FUNC_W-1:0]  func_ff, func_in;
   logic [IDX_W-1:0]   op_idx_ff, op_idx_in;
   logic               op_in_range_ff, op_in_range_in;
   logic               res_ok_ff, res_ok_in;
   logic [ADDR_W-1:0]  res_addr_ff, res_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;

   logic [BYTES_W:0]   bytes_sum;
   logic [NEED_W-1:0]  req_need;
   logic               req_need_ok;
   logic [ADDR_W-1:0]  req_page_num;
   logic [IDX_W-1:0]   req_page_idx;
   logic               req_in_range;
   logic [RUN_W-1:0]   run_len;

   assign bytes_sum    = {1'b0, req_if.payload.request_bytes} + (BYTES_W + 1)'(PAGE_BYTES - 1);
   assign req_need     = NEED_W'(bytes_sum >> PAGE_SHIFT);
   assign req_need_ok  = (req_need != '0) && (req_need <= NEED_W'(NUM_PAGES));
   assign req_page_num = req_if.payload.page_address >> PAGE_SHIFT;
   assign req_page_idx = req_page_num[IDX_W-1:0];
   assign req_in_range = req_page_num < ADDR_W'(NUM_PAGES);
   assign run_len      = run_top_ff - RUN_W'(eval_idx_ff);

   assign req_if.ready          = (state_ff == ST_IDLE);
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.payload.ok     = rsp_ok_ff;
   assign rsp_if.payload.alloc_address = rsp_addr_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_comb begin
      state_in       = state_ff;
      ptr_in         = ptr_ff;
      left_in        = left_ff;
      scan_addr_in   = scan_addr_ff;
      scan_more_in   = scan_more_ff;
      eval_valid_in  = eval_valid_ff;
      eval_idx_in    = eval_idx_ff;
      run_top_in     = run_top_ff;
      need_in        = need_ff;
      func_in        = func_ff;
      op_idx_in      = op_idx_ff;
      op_in_range_in = op_in_range_ff;
      res_ok_in      = res_ok_ff;
      res_addr_in    = res_addr_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_ok_in      = rsp_ok_ff;
      rsp_addr_in    = rsp_addr_ff;

      mem_we    = 1'b0;
      mem_waddr = ptr_ff;
      mem_wdata = '0;
      mem_raddr = scan_addr_ff;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = '0;
            ptr_in    = ptr_ff + IDX_W'(1);
            if (ptr_ff == IDX_W'(NUM_PAGES - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            mem_raddr = req_page_idx;
            if (req_if.valid) begin
               func_in        = req_if.payload.func;
               op_idx_in      = req_page_idx;
               op_in_range_in = req_in_range;
               need_in        = RUN_W'(req_need);
               res_ok_in      = 1'b0;
               res_addr_in    = '0;
               unique case (req_if.payload.func)
                  FUNC_ALLOC: begin
                     if (req_need_ok) begin
                        scan_addr_in  = IDX_W'(NUM_PAGES - 1);
                        scan_more_in  = 1'b1;
                        eval_valid_in = 1'b0;
                        run_top_in    = RUN_W'(NUM_PAGES);
                        state_in      = ST_SCAN;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  FUNC_INC, FUNC_FREE: begin
                     state_in = ST_RMW;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            mem_raddr     = scan_addr_ff;
            eval_valid_in = scan_more_ff;
            eval_idx_in   = scan_addr_ff;
            if (scan_more_ff) begin
               scan_addr_in = scan_addr_ff - IDX_W'(1);
               if (scan_addr_ff == '0) begin
                  scan_more_in = 1'b0;
               end
            end
            if (eval_valid_ff) begin
               if (rd_data_ff != '0) begin
                  run_top_in = RUN_W'(eval_idx_ff);
                  if (eval_idx_ff == '0) begin
                     state_in = ST_DONE;
                  end
               end else if (run_len == need_ff) begin
                  ptr_in      = eval_idx_ff;
                  left_in     = need_ff;
                  res_addr_in = ADDR_W'(eval_idx_ff) << PAGE_SHIFT;
                  state_in    = ST_FILL;
               end else if (eval_idx_ff == '0) begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = COUNT_W'(1);
            ptr_in    = ptr_ff + IDX_W'(1);
            left_in   = left_ff - RUN_W'(1);
            if (left_ff == RUN_W'(1)) begin
               res_ok_in = 1'b1;
               state_in  = ST_DONE;
            end
         end

         ST_RMW: begin
            mem_waddr = op_idx_ff;
            if (op_in_range_ff) begin
               if (func_ff == FUNC_INC) begin
                  if (rd_data_ff < COUNT_W'(REF_CEILING - 1)) begin
                     mem_we    = 1'b1;
                     mem_wdata = rd_data_ff + COUNT_W'(1);
                     res_ok_in = 1'b1;
                  end
               end else if (rd_data_ff != '0) begin
                  mem_we    = 1'b1;
                  mem_wdata = rd_data_ff - COUNT_W'(1);
                  res_ok_in = 1'b1;
               end
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_addr_in  = res_addr_ff;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         ptr_ff         <= '0;
         left_ff        <= '0;
         scan_addr_ff   <= '0;
         scan_more_ff   <= 1'b0;
         eval_valid_ff  <= 1'b0;
         eval_idx_ff    <= '0;
         run_top_ff     <= '0;
         need_ff        <= '0;
         func_ff        <= '0;
         op_idx_ff      <= '0;
         op_in_range_ff <= 1'b0;
         res_ok_ff      <= 1'b0;
         res_addr_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         rsp_ok_ff      <= 1'b0;
         rsp_addr_ff    <= '0;
      end else begin
         state_ff       <= state_in;
         ptr_ff         <= ptr_in;
         left_ff        <= left_in;
         scan_addr_ff   <= scan_addr_in;
         scan_more_ff   <= scan_more_in;
         eval_valid_ff  <= eval_valid_in;
         eval_idx_ff    <= eval_idx_in;
         run_top_ff     <= run_top_in;
         need_ff        <= need_in;
         func_ff        <= func_in;
         op_idx_ff      <= op_idx_in;
         op_in_range_ff <= op_in_range_in;
         res_ok_ff      <= res_ok_in;
         res_addr_ff    <= res_addr_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_ok_ff      <= rsp_ok_in;
         rsp_addr_ff    <= rsp_addr_in;
      end
   end

endmodule

// ===== tb/page_map_checker.sv =====
module page_map_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  prca_pkg::prca_req_type req_item,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  prca_pkg::prca_rsp_type rsp_item,
   output int                     outstanding,
   output int                     fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import prca_pkg::*;

   logic [COUNT_W-1:0] page_counts [NUM_PAGES];
   prca_rsp_type       expected_q [$];
   int                 fail_total = 0;

   function automatic prca_rsp_type apply_request(input prca_req_type item);
      prca_rsp_type outcome;
      int need;
      int run_top;
      int first;
      int scan;
      int page;
      outcome = '0;
      page = int'(item.page_address) / PAGE_BYTES;
      case (item.func)
         FUNC_ALLOC: begin
            need    = (int'(item.request_bytes) + PAGE_BYTES - 1) / PAGE_BYTES;
            run_top = NUM_PAGES;
            first   = -1;
            scan    = NUM_PAGES;
            while (scan > 0 && first < 0) begin
               scan--;
               if (page_counts[scan] != '0)
                  run_top = scan;
               else if (run_top - scan == need)
                  first = scan;
            end
            if (first >= 0) begin
               for (int k = 0; k < need; k++)
                  page_counts[first + k] = COUNT_W'(1);
               outcome.ok            = 1'b1;
               outcome.alloc_address = ADDR_W'(first * PAGE_BYTES);
            end
         end
         FUNC_INC: begin
            if (page < NUM_PAGES && page_counts[page] < COUNT_W'(REF_CEILING - 1)) begin
               page_counts[page] = page_counts[page] + COUNT_W'(1);
               outcome.ok = 1'b1;
            end
         end
         FUNC_FREE: begin
            if (page < NUM_PAGES && page_counts[page] != '0) begin
               page_counts[page] = page_counts[page] - COUNT_W'(1);
               outcome.ok = 1'b1;
            end
         end
         default: begin
         end
      endcase
      return outcome;
   endfunction

   always @(posedge clock) begin : track
      prca_rsp_type want;
      if (reset) begin
         for (int p = 0; p < NUM_PAGES; p++)
            page_counts[p] = '0;
         expected_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display("%0t: unexpected result ok=%0b addr=%h", $realtime,
                           rsp_item.ok, rsp_item.alloc_address);
            end else begin
               want = expected_q.pop_front();
               if (rsp_item.ok !== want.ok || rsp_item.alloc_address !== want.alloc_address) begin
                  fail_total++;
                  if (fail_total <= 10)
                     $display("%0t: mismatch, expected ok=%0b addr=%h, got ok=%0b addr=%h",
                              $realtime, want.ok, want.alloc_address,
                              rsp_item.ok, rsp_item.alloc_address);
               end
            end
         end
         if (req_valid && req_ready)
            expected_q.push_back(apply_request(req_item));
      end
      outstanding <= expected_q.size();
      fail_count  <= fail_total;
   end

endmodule

// ===== tb/tb_page_refcount_allocator_unit.sv =====
module tb_page_refcount_allocator_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import prca_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int STALL_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 2100;
   localparam int LONG_HOLD    = 300;
   localparam int HOT_PAGE     = 3;

   logic clock;
   logic reset;
   int   outstanding;
   int   fail_count;
   int   send_idle_pct = 15;
   int   recv_idle_pct = 72;
   int   hold_request  = 0;
   int   handed_out    = 0;

   prca_req_if req_ch ();
   prca_rsp_if rsp_ch ();

   page_refcount_allocator_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   page_map_checker audit (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .req_item    (req_ch.payload),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_item    (rsp_ch.payload),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : ready_drive
      int hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   task automatic send_item(input logic [FUNC_W-1:0] func, input int unsigned bytes,
                            input int unsigned addr);
      prca_req_type item;
      item.func          = func;
      item.request_bytes = bytes[BYTES_W-1:0];
      item.page_address  = addr[ADDR_W-1:0];
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= item;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic alloc_bytes(input int unsigned bytes);
      send_item(FUNC_ALLOC, bytes, $urandom_range(0, 2**ADDR_W - 1));
   endtask

   task automatic page_op(input logic [FUNC_W-1:0] func, input int unsigned addr);
      send_item(func, $urandom_range(0, 2**BYTES_W - 1), addr);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic int unsigned page_addr(input int page);
      return (int'(page) << PAGE_SHIFT) | $urandom_range(0, PAGE_BYTES - 1);
   endfunction

   function automatic int unsigned target_address();
      int span;
      span = (handed_out + 8 < NUM_PAGES - 1) ? handed_out + 8 : NUM_PAGES - 1;
      if ($urandom_range(99) < 70)
         return page_addr(NUM_PAGES - 1 - int'($urandom_range(0, span)));
      return $urandom_range(0, 2**ADDR_W - 1);
   endfunction

   task automatic random_item();
      int roll;
      int pages;
      roll = $urandom_range(99);
      if (roll < 35) begin
         roll = $urandom_range(99);
         if (roll < 95) begin
            pages = (roll < 80) ? $urandom_range(1, 4) : $urandom_range(5, 16);
            handed_out = (handed_out + pages < NUM_PAGES) ? handed_out + pages : NUM_PAGES - 1;
            alloc_bytes(pages * PAGE_BYTES - $urandom_range(0, PAGE_BYTES - 1));
         end else begin
            alloc_bytes($urandom_range(0, 2**BYTES_W - 1));
         end
      end else if (roll < 60) begin
         page_op(FUNC_INC, target_address());
      end else if (roll < 97) begin
         page_op(FUNC_FREE, target_address());
      end else begin
         send_item(FUNC_UNUSED, $urandom_range(0, 2**BYTES_W - 1),
                   $urandom_range(0, 2**ADDR_W - 1));
      end
   endtask

   initial begin
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      reset          <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      alloc_bytes(0);
      alloc_bytes(2**BYTES_W - 1);
      alloc_bytes(NUM_PAGES * PAGE_BYTES + 1);
      alloc_bytes(1);
      alloc_bytes(NUM_PAGES * PAGE_BYTES);
      alloc_bytes(PAGE_BYTES);
      alloc_bytes(PAGE_BYTES + 1);
      page_op(FUNC_INC, 2**ADDR_W - 1);
      repeat (3) page_op(FUNC_FREE, page_addr(NUM_PAGES - 1));
      alloc_bytes(PAGE_BYTES);
      page_op(FUNC_FREE, 0);
      page_op(FUNC_INC, 0);
      page_op(FUNC_FREE, 0);
      send_item(FUNC_UNUSED, 2**BYTES_W - 1, 2**ADDR_W - 1);
      alloc_bytes(3 * PAGE_BYTES);
      alloc_bytes(64 * PAGE_BYTES);
      page_op(FUNC_FREE, page_addr(NUM_PAGES - 3));
      alloc_bytes(PAGE_BYTES);
      handed_out = 80;
      repeat (100) random_item();
      wait_drained();

      send_idle_pct = 72;
      recv_idle_pct = 15;
      repeat (100) random_item();
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = LONG_HOLD;
      repeat (REF_CEILING + 3) page_op(FUNC_INC, page_addr(HOT_PAGE));
      repeat (2) page_op(FUNC_FREE, page_addr(HOT_PAGE));
      repeat (100) random_item();
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== page_refcount_allocator_unit.f =====
hw/rtl/prca_pkg.sv
hw/rtl/prca_channels.sv
hw/rtl/page_refcount_allocator_unit.sv
tb/page_map_checker.sv
tb/tb_page_refcount_allocator_unit.sv
